FILE: sv/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared widths, register codes, bundle types and helpers for the PID
// controller with setpoint feedforward and integral anti-windup.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 24;
    localparam int DATA_W     = 32;
    localparam int LIMIT_W    = 31;
    localparam int CFG_IDX_W  = 3;

    localparam int HIST_DEPTH = 4;
    localparam int PTR_W      = $clog2(HIST_DEPTH);
    localparam int MEAN_TAPS  = 4;
    localparam int TAP_SHIFT  = $clog2(MEAN_TAPS);

    localparam int ERR_W  = SAMPLE_W + 1;
    localparam int SUM4_W = SAMPLE_W + TAP_SHIFT;
    localparam int DIFF_W = SAMPLE_W + TAP_SHIFT + 1;
    localparam int ACC_W  = DATA_W + 1;

    localparam int F_W    = GAIN_W + SAMPLE_W;
    localparam int P_W    = GAIN_W + ERR_W;
    localparam int I_W    = GAIN_W + DATA_W;
    localparam int D_W    = GAIN_W + DIFF_W;
    localparam int PCL_W  = P_W + 1;
    localparam int ICL_W  = I_W + 1;
    localparam int DN_W   = D_W + 1;
    localparam int SUM_W  = I_W + 4;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_GAIN   = 3'd0,
        REG_KI_GAIN   = 3'd1,
        REG_KD_GAIN   = 3'd2,
        REG_KF_GAIN   = 3'd3,
        REG_OUT_MIN   = 3'd4,
        REG_OUT_MAX   = 3'd5,
        REG_I_LIMIT   = 3'd6,
        REG_ESUM_LIM  = 3'd7
    } cfg_reg_t;

    localparam logic ACT_STEP    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp_gain;
        logic signed [GAIN_W-1:0] ki_gain;
        logic signed [GAIN_W-1:0] kd_gain;
        logic signed [GAIN_W-1:0] kf_gain;
        logic signed [DATA_W-1:0] out_min;
        logic signed [DATA_W-1:0] out_max;
        logic [LIMIT_W-1:0]       i_limit;
        logic [LIMIT_W-1:0]       error_sum_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]    err;
        logic signed [SAMPLE_W-1:0] tgt;
        logic signed [DATA_W-1:0]   accum;
        logic signed [DIFF_W-1:0]   diff;
    } front_t;

    typedef struct packed {
        logic signed [F_W-1:0] f_prod;
        logic signed [P_W-1:0] p_prod;
        logic signed [I_W-1:0] i_prod;
        logic signed [D_W-1:0] d_prod;
    } prod_t;

    function automatic logic [PTR_W-1:0] ptr_add(
        input logic [PTR_W-1:0] base,
        input logic [PTR_W-1:0] step
    );
        logic [PTR_W:0] s;
        s = {1'b0, base} + {1'b0, step};
        if (s >= (PTR_W+1)'(HIST_DEPTH))
        begin
            s = s - (PTR_W+1)'(HIST_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

FILE: sv/pfc_if.sv
// ----------------------------------------------------------------------------
// pfc_if
// Valid/ready channels of the controller: sample beats, result beats and
// configuration register writes.
// ----------------------------------------------------------------------------
interface pfc_sample_if;
    logic                valid;
    logic                ready;
    logic                action;
    logic signed [15:0]  measured;
    logic signed [15:0]  target;

    modport source (output valid, output action, output measured, output target,
                    input ready);
    modport sink   (input valid, input action, input measured, input target,
                    output ready);
endinterface

interface pfc_result_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

interface pfc_cfg_if;
    logic         valid;
    logic         ready;
    logic [2:0]   index;
    logic [31:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/pfc_regs.sv
// ----------------------------------------------------------------------------
// pfc_regs
// Configuration register file: gains, output limits and integral limits.
// ----------------------------------------------------------------------------
module pfc_regs (
    input  logic          clk,
    input  logic          rst_n,
    pfc_cfg_if.sink       cfg,
    output pfc_pkg::cfg_t regs
);
    import pfc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_KP_GAIN:  cfg_next.kp_gain         = cfg.data[GAIN_W-1:0];
                REG_KI_GAIN:  cfg_next.ki_gain         = cfg.data[GAIN_W-1:0];
                REG_KD_GAIN:  cfg_next.kd_gain         = cfg.data[GAIN_W-1:0];
                REG_KF_GAIN:  cfg_next.kf_gain         = cfg.data[GAIN_W-1:0];
                REG_OUT_MIN:  cfg_next.out_min         = cfg.data[DATA_W-1:0];
                REG_OUT_MAX:  cfg_next.out_max         = cfg.data[DATA_W-1:0];
                REG_I_LIMIT:  cfg_next.i_limit         = cfg.data[LIMIT_W-1:0];
                REG_ESUM_LIM: cfg_next.error_sum_limit = cfg.data[LIMIT_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/pfc_front.sv
// ----------------------------------------------------------------------------
// pfc_front
// Accepts sample beats, keeps the history ring and the error sum, and
// registers error, setpoint, old error sum and history difference.
// ----------------------------------------------------------------------------
module pfc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  pfc_pkg::cfg_t   cfg,
    pfc_sample_if.sink      sample,
    output logic            front_valid,
    output pfc_pkg::front_t front,
    input  logic            front_ready
);
    import pfc_pkg::*;

    logic signed [SAMPLE_W-1:0] hist_reg [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] hist_next [HIST_DEPTH];
    logic [PTR_W-1:0]           ptr_reg;
    logic [PTR_W-1:0]           ptr_next;
    logic signed [DATA_W-1:0]   accum_reg;
    logic signed [DATA_W-1:0]   accum_next;
    logic                       first_reg;
    logic                       first_next;
    logic                       front_valid_reg;
    logic                       front_valid_next;
    front_t                     front_reg;

    logic                       accept;
    logic                       step;
    logic signed [ERR_W-1:0]    err;
    logic signed [SUM4_W-1:0]   sum4;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [DATA_W-1:0]   acc_base;
    logic signed [ACC_W-1:0]    acc_sum;
    logic signed [ACC_W-1:0]    acc_hi;
    logic signed [ACC_W-1:0]    acc_lo;
    logic signed [ACC_W-1:0]    acc_cl;
    logic [PTR_W-1:0]           wr_ptr;

    assign sample.ready = !front_valid_reg || front_ready;
    assign accept       = sample.valid && sample.ready;
    assign step         = accept && (sample.action == ACT_STEP);
    assign front_valid  = front_valid_reg;
    assign front        = front_reg;

    always_comb
    begin
        err  = ERR_W'(sample.target) - ERR_W'(sample.measured);
        sum4 = '0;
        for (int a = 0; a < MEAN_TAPS; a++)
        begin
            if (first_reg)
            begin
                sum4 = sum4 + SUM4_W'(sample.measured);
            end
            else
            begin
                sum4 = sum4 + SUM4_W'(hist_reg[ptr_add(ptr_reg, PTR_W'(a))]);
            end
        end
        diff = (DIFF_W'(sample.measured) <<< TAP_SHIFT) - DIFF_W'(sum4);

        acc_base = first_reg ? '0 : accum_reg;
        acc_sum  = ACC_W'(acc_base) + ACC_W'(err);
        if (cfg.i_limit != '0)
        begin
            acc_hi = ACC_W'(cfg.error_sum_limit);
            acc_lo = -ACC_W'(cfg.error_sum_limit);
        end
        else
        begin
            acc_hi = ACC_W'(DATA_MAX);
            acc_lo = ACC_W'(DATA_MIN);
        end
        if (acc_sum > acc_hi)
        begin
            acc_cl = acc_hi;
        end
        else if (acc_sum < acc_lo)
        begin
            acc_cl = acc_lo;
        end
        else
        begin
            acc_cl = acc_sum;
        end

        wr_ptr = first_reg ? '0 : ptr_reg;
    end

    always_comb
    begin
        hist_next        = hist_reg;
        ptr_next         = ptr_reg;
        accum_next       = accum_reg;
        first_next       = first_reg;
        front_valid_next = front_valid_reg && !front_ready;
        if (accept && (sample.action == ACT_RESTART))
        begin
            first_next = 1'b1;
            accum_next = '0;
        end
        else if (step)
        begin
            for (int a = 0; a < HIST_DEPTH; a++)
            begin
                if (first_reg || (PTR_W'(a) == wr_ptr))
                begin
                    hist_next[a] = sample.measured;
                end
            end
            ptr_next         = ptr_add(wr_ptr, PTR_W'(1));
            accum_next       = acc_cl[DATA_W-1:0];
            first_next       = 1'b0;
            front_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < HIST_DEPTH; a++)
            begin
                hist_reg[a] <= '0;
            end
            ptr_reg         <= '0;
            accum_reg       <= '0;
            first_reg       <= 1'b1;
            front_valid_reg <= 1'b0;
        end
        else
        begin
            hist_reg        <= hist_next;
            ptr_reg         <= ptr_next;
            accum_reg       <= accum_next;
            first_reg       <= first_next;
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            front_reg.err   <= err;
            front_reg.tgt   <= sample.target;
            front_reg.accum <= acc_base;
            front_reg.diff  <= diff;
        end
    end

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (sample.action == ACT_RESTART) |=> first_reg && (accum_reg == '0))
        else $error("restart did not clear the error sum");

    a_step_loads: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> !first_reg && front_valid_reg)
        else $error("compute beat did not load the front stage");

    a_ptr_advance: assert property (@(posedge clk) disable iff (!rst_n)
        step && !first_reg |=> ptr_reg == ptr_add($past(ptr_reg), PTR_W'(1)))
        else $error("history pointer did not advance");

endmodule

FILE: sv/pfc_mult.sv
// ----------------------------------------------------------------------------
// pfc_mult
// Gain multiplies for the four terms, one registered product each.
// ----------------------------------------------------------------------------
module pfc_mult (
    input  logic            clk,
    input  logic            rst_n,
    input  pfc_pkg::cfg_t   cfg,
    input  logic            front_valid,
    input  pfc_pkg::front_t front,
    output logic            front_ready,
    output logic            prod_valid,
    output pfc_pkg::prod_t  prod,
    input  logic            prod_ready
);
    import pfc_pkg::*;

    logic  prod_valid_reg;
    logic  prod_valid_next;
    prod_t prod_reg;
    prod_t prod_next;
    logic  load;

    assign front_ready = !prod_valid_reg || prod_ready;
    assign load        = front_valid && front_ready;
    assign prod_valid  = prod_valid_reg;
    assign prod        = prod_reg;

    always_comb
    begin
        prod_next.f_prod = F_W'(cfg.kf_gain) * F_W'($signed(front.tgt));
        prod_next.p_prod = P_W'(cfg.kp_gain) * P_W'($signed(front.err));
        prod_next.i_prod = I_W'(cfg.ki_gain) * I_W'($signed(front.accum));
        prod_next.d_prod = D_W'(cfg.kd_gain) * D_W'($signed(front.diff));
        prod_valid_next  = load || (prod_valid_reg && !prod_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

FILE: sv/pfc_combine.sv
// ----------------------------------------------------------------------------
// pfc_combine
// Clamps the P term, the I term when i_limit is nonzero, forms the D term,
// sums, applies the output limits unless min equals max, holds the result beat.
// ----------------------------------------------------------------------------
module pfc_combine (
    input  logic           clk,
    input  logic           rst_n,
    input  pfc_pkg::cfg_t  cfg,
    input  logic           prod_valid,
    input  pfc_pkg::prod_t prod,
    output logic           prod_ready,
    pfc_result_if.source   result
);
    import pfc_pkg::*;

    logic                     result_valid_reg;
    logic                     result_valid_next;
    logic signed [DATA_W-1:0] drive_reg;
    logic                     load;

    logic signed [PCL_W-1:0]  p_ext;
    logic signed [PCL_W-1:0]  p_hi;
    logic signed [PCL_W-1:0]  p_cl;
    logic signed [ICL_W-1:0]  i_ext;
    logic signed [ICL_W-1:0]  i_hi;
    logic signed [ICL_W-1:0]  i_cl;
    logic signed [DN_W-1:0]   d_neg;
    logic signed [DN_W-1:0]   d_term;
    logic signed [SUM_W-1:0]  total;
    logic signed [SUM_W-1:0]  lim;
    logic signed [DATA_W-1:0] drive_next;

    assign prod_ready   = !result_valid_reg || result.ready;
    assign load         = prod_valid && prod_ready;
    assign result.valid = result_valid_reg;
    assign result.drive = drive_reg;

    always_comb
    begin
        p_ext = PCL_W'($signed(prod.p_prod));
        p_hi  = PCL_W'(cfg.out_max);
        if (p_ext > p_hi)
        begin
            p_cl = p_hi;
        end
        else if (p_ext < -p_hi)
        begin
            p_cl = -p_hi;
        end
        else
        begin
            p_cl = p_ext;
        end

        i_ext = ICL_W'($signed(prod.i_prod));
        i_hi  = ICL_W'(cfg.i_limit);
        i_cl  = i_ext;
        if (cfg.i_limit != '0)
        begin
            if (i_ext > i_hi)
            begin
                i_cl = i_hi;
            end
            else if (i_ext < -i_hi)
            begin
                i_cl = -i_hi;
            end
        end

        // floor of the negated product over the tap count
        d_neg  = -DN_W'($signed(prod.d_prod));
        d_term = d_neg >>> TAP_SHIFT;

        total = SUM_W'($signed(prod.f_prod)) + SUM_W'(p_cl) + SUM_W'(i_cl)
              + SUM_W'(d_term);

        lim = total;
        if (cfg.out_min != cfg.out_max)
        begin
            if (total > SUM_W'(cfg.out_max))
            begin
                lim = SUM_W'(cfg.out_max);
            end
            else if (total < SUM_W'(cfg.out_min))
            begin
                lim = SUM_W'(cfg.out_min);
            end
        end

        if (lim > SUM_W'(DATA_MAX))
        begin
            drive_next = DATA_MAX;
        end
        else if (lim < SUM_W'(DATA_MIN))
        begin
            drive_next = DATA_MIN;
        end
        else
        begin
            drive_next = lim[DATA_W-1:0];
        end

        result_valid_next = load || (result_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg <= drive_next;
        end
    end

    a_out_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && (cfg.out_min < cfg.out_max)
        |-> (drive_reg <= cfg.out_max) && (drive_reg >= cfg.out_min))
        else $error("drive outside output limits");

endmodule

FILE: sv/pid_feedforward_controller.sv
// ----------------------------------------------------------------------------
// pid_feedforward_controller
// PID controller with setpoint feedforward and integral anti-windup, Q16.16.
// Pipeline: a compute beat passes the front register, product register and
// result register in that order before its result shows.
// Throughput: one sample beat per cycle while results are taken; restart beats give no result.
// The error sum and history update at acceptance, so beats follow back to back.
// Reset clears the gains, limits, history ring and error sum and arms first step.
// ----------------------------------------------------------------------------
module pid_feedforward_controller (
    input  logic         clk,
    input  logic         rst_n,
    pfc_sample_if.sink   sample,
    pfc_result_if.source result,
    pfc_cfg_if.sink      cfg
);
    import pfc_pkg::*;

    cfg_t   regs;
    logic   front_valid;
    logic   front_ready;
    front_t front;
    logic   prod_valid;
    logic   prod_ready;
    prod_t  prod;

    pfc_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    pfc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (regs),
        .sample      (sample),
        .front_valid (front_valid),
        .front       (front),
        .front_ready (front_ready)
    );

    pfc_mult u_mult (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (regs),
        .front_valid (front_valid),
        .front       (front),
        .front_ready (front_ready),
        .prod_valid  (prod_valid),
        .prod        (prod),
        .prod_ready  (prod_ready)
    );

    pfc_combine u_combine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (regs),
        .prod_valid (prod_valid),
        .prod       (prod),
        .prod_ready (prod_ready),
        .result     (result)
    );

endmodule
